[sv/tssu_pkg.sv]
// Package for the thread sync unit: command and status codes, controller state type.
// No dependencies.
package tssu_pkg;

  typedef enum logic [2:0] {
    CMD_CREATE = 3'd0,
    CMD_YIELD  = 3'd1,
    CMD_EXIT   = 3'd2,
    CMD_LOCK   = 3'd3,
    CMD_UNLOCK = 3'd4,
    CMD_WAIT   = 3'd5,
    CMD_SIGNAL = 3'd6,
    CMD_JOIN   = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BUSY     = 3'd1,
    ST_BAD_IDX  = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_NOT_HELD = 3'd5,
    ST_HALT     = 3'd6,
    ST_DEADLOCK = 3'd7
  } status_t;

  // Controller states, one-hot
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RDQ    = 6'b000010,
    S_EXEC   = 6'b000100,
    S_RDSLOT = 6'b001000,
    S_SEARCH = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic exec;      // apply command updates
    logic slot_done; // slot read data valid: unblock waiter
    logic srch_init; // start round-robin search
    logic srch_step; // examine one candidate
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_slot; // signal will pop a queue slot
    logic need_sw;   // command needs a thread switch
    logic srch_end;  // search finished this step
  } dp_sts_t;

endpackage

[sv/thread_scheduler_sync_unit.sv]
// Thread sync unit: round-robin scheduler with locks and FIFO condition queues.
// Flow: S_RDQ (queue pointer RAM read), S_EXEC, then S_OUT; signal adds S_RDSLOT
//   (slot RAM read); a switch adds S_SEARCH, one thread per cycle (1 up to MAX_THREADS).
// Throughput: one item at a time; the next item is taken the cycle after the
//   result transfers.
// Reset: synchronous active-low rst_n; main thread 0 runs, all tables empty.
module thread_scheduler_sync_unit import tssu_pkg::*; #(
  parameter int MAX_THREADS    = 16,
  parameter int LOCK_COUNT     = 16,
  parameter int CONDS_PER_LOCK = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_cmd,
  input  logic [3:0] in_lock_index,
  input  logic [1:0] in_cond_index,
  input  logic [3:0] in_target_thread,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [3:0] out_run_thread,
  output logic [3:0] out_new_thread,
  output logic       out_target_done
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tssu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tssu_dp #(
    .MAX_THREADS    (MAX_THREADS),
    .LOCK_COUNT     (LOCK_COUNT),
    .CONDS_PER_LOCK (CONDS_PER_LOCK)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_cmd           (in_cmd),
    .in_lock_index    (in_lock_index),
    .in_cond_index    (in_cond_index),
    .in_target_thread (in_target_thread),
    .out_status       (out_status),
    .out_run_thread   (out_run_thread),
    .out_new_thread   (out_new_thread),
    .out_target_done  (out_target_done)
  );

endmodule

[sv/tssu_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module tssu_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/tssu_ctrl.sv]
// Controller state machine of the thread sync unit.
// Depends on tssu_pkg.
module tssu_ctrl import tssu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RDQ;
        end
      end
      // queue pointer RAM read in flight
      S_RDQ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.need_slot) begin
          state_nxt = S_RDSLOT;
        end else if (sts.need_sw) begin
          cmd.srch_init = 1'b1;
          state_nxt     = S_SEARCH;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_RDSLOT: begin
        cmd.slot_done = 1'b1;
        state_nxt     = S_OUT;
      end
      S_SEARCH: begin
        cmd.srch_step = 1'b1;
        if (sts.srch_end) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/tssu_dp.sv]
// Datapath of the thread sync unit: thread flags, lock table, condition queues,
// round-robin search. Depends on tssu_pkg and tssu_ram.
module tssu_dp import tssu_pkg::*; #(
  parameter int MAX_THREADS    = 16,
  parameter int LOCK_COUNT     = 16,
  parameter int CONDS_PER_LOCK = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts,
  input  logic [2:0] in_cmd,
  input  logic [3:0] in_lock_index,
  input  logic [1:0] in_cond_index,
  input  logic [3:0] in_target_thread,
  output logic [2:0] out_status,
  output logic [3:0] out_run_thread,
  output logic [3:0] out_new_thread,
  output logic       out_target_done
);

  localparam int TW  = (MAX_THREADS > 2) ? $clog2(MAX_THREADS) : 1;
  localparam int CW  = $clog2(MAX_THREADS + 1);
  localparam int LW  = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam int CQW = (CONDS_PER_LOCK > 1) ? $clog2(CONDS_PER_LOCK) : 1;
  localparam int QN  = LOCK_COUNT * CONDS_PER_LOCK;
  localparam int QW  = (QN > 1) ? $clog2(QN) : 1;
  localparam int SD  = QN * MAX_THREADS;
  localparam int SW  = $clog2(SD);
  localparam int PW  = 2 * TW + CW;

  function automatic logic [TW-1:0] wrap_next(input logic [TW-1:0] t,
                                              input logic [CW-1:0] n);
    wrap_next = (32'(t) + 1 >= 32'(n)) ? '0 : TW'(32'(t) + 1);
  endfunction

  // Captured item
  logic [2:0] cmd_r;
  logic [3:0] li_r;
  logic [1:0] ci_r;
  logic [3:0] tt_r;

  // State
  logic [MAX_THREADS-1:0] fin_r, blk_r;
  logic [TW-1:0]          run_r;
  logic [CW-1:0]          made_r;
  logic [LOCK_COUNT-1:0]  ltaken_r;
  logic [QN-1:0]          qv_r;

  // Result and search registers
  logic [2:0]    status_r;
  logic [3:0]    newt_r;
  logic          tdone_r;
  logic [TW-1:0] cand_r;
  logic [CW-1:0] cnt_r;

  // Index decode
  logic          lock_ok, pair_ok;
  logic [LW-1:0] li;
  logic [QW-1:0] q;
  assign lock_ok = 32'(li_r) < LOCK_COUNT;
  assign pair_ok = lock_ok && (32'(ci_r) < CONDS_PER_LOCK);
  assign li      = LW'(li_r);
  assign q       = pair_ok ? QW'(32'(li) * CONDS_PER_LOCK + 32'(CQW'(ci_r))) : '0;

  logic tt_ok;
  assign tt_ok = (32'(tt_r) < 32'(made_r)) && (32'(tt_r) < MAX_THREADS);

  // Queue pointer memory: head, tail and fill per queue; unwritten rows read as zero
  logic          qp_we;
  logic [PW-1:0] qp_wdata, qp_rdata;
  logic [TW-1:0] qhead, qtail, qhead_upd, qtail_upd;
  logic [CW-1:0] qfill, qfill_upd;
  assign {qhead, qtail, qfill} = qv_r[q] ? qp_rdata : '0;

  tssu_ram #(.WIDTH(PW), .DEPTH(QN)) u_qptr (
    .clk   (clk),
    .we    (qp_we),
    .waddr (q),
    .wdata (qp_wdata),
    .raddr (q),
    .rdata (qp_rdata)
  );

  // Decide what the command does
  logic    sw_req, slot_req, ex_ok;
  status_t ex_st;
  always_comb begin
    sw_req   = 1'b0;
    slot_req = 1'b0;
    ex_ok    = 1'b0;
    ex_st    = ST_OK;
    case (cmd_t'(cmd_r))
      CMD_CREATE: begin
        if (32'(made_r) >= MAX_THREADS) ex_st = ST_FULL;
        else ex_ok = 1'b1;
      end
      CMD_YIELD: sw_req = 1'b1;
      CMD_EXIT: begin
        if (run_r == '0) ex_st = ST_HALT;
        else begin
          ex_ok  = 1'b1;
          sw_req = 1'b1;
        end
      end
      CMD_LOCK: begin
        if (!lock_ok) ex_st = ST_BAD_IDX;
        else if (ltaken_r[li]) begin
          ex_st  = ST_BUSY;
          sw_req = 1'b1;
        end else ex_ok = 1'b1;
      end
      CMD_UNLOCK: begin
        if (!lock_ok) ex_st = ST_BAD_IDX;
        else ex_ok = 1'b1;
      end
      CMD_WAIT: begin
        if (!pair_ok) ex_st = ST_BAD_IDX;
        else if (!ltaken_r[li]) ex_st = ST_NOT_HELD;
        else if (32'(qfill) >= MAX_THREADS) ex_st = ST_FULL;
        else begin
          ex_ok  = 1'b1;
          sw_req = 1'b1;
        end
      end
      CMD_SIGNAL: begin
        if (!pair_ok) ex_st = ST_BAD_IDX;
        else if (qfill == '0) ex_st = ST_EMPTY;
        else begin
          ex_ok    = 1'b1;
          slot_req = 1'b1;
        end
      end
      CMD_JOIN: begin
        if (!tt_ok) ex_st = ST_BAD_IDX;
        else if (!fin_r[TW'(tt_r)]) sw_req = 1'b1;
      end
      default: ex_st = ST_OK;
    endcase
  end

  assign sts.need_slot = slot_req;
  assign sts.need_sw   = sw_req;

  // Pointer update: wait pushes at tail, signal pops at head
  always_comb begin
    qhead_upd = qhead;
    qtail_upd = qtail;
    qfill_upd = qfill;
    if (cmd_t'(cmd_r) == CMD_WAIT) begin
      qtail_upd = wrap_next(qtail, CW'(MAX_THREADS));
      qfill_upd = qfill + CW'(1);
    end else begin
      qhead_upd = wrap_next(qhead, CW'(MAX_THREADS));
      qfill_upd = qfill - CW'(1);
    end
  end

  assign qp_we    = cmd.exec && ex_ok &&
                    (cmd_t'(cmd_r) == CMD_WAIT || cmd_t'(cmd_r) == CMD_SIGNAL);
  assign qp_wdata = {qhead_upd, qtail_upd, qfill_upd};

  // Slot memory: one row of MAX_THREADS per queue
  logic          ram_we;
  logic [SW-1:0] ram_waddr, ram_raddr;
  logic [TW-1:0] ram_rdata;
  assign ram_we    = cmd.exec && ex_ok && (cmd_t'(cmd_r) == CMD_WAIT);
  assign ram_waddr = SW'(32'(q) * MAX_THREADS + 32'(qtail));
  assign ram_raddr = SW'(32'(q) * MAX_THREADS + 32'(qhead));

  tssu_ram #(.WIDTH(TW), .DEPTH(SD)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (run_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Round-robin search: one candidate per cycle
  logic [CW-1:0] n_eff;
  logic [TW-1:0] nxt_cand;
  logic          cand_free, last_step;
  assign n_eff     = (made_r == '0 || 32'(made_r) > MAX_THREADS) ? CW'(1) : made_r;
  assign nxt_cand  = (32'(cand_r) + 1 >= 32'(n_eff)) ? '0 : TW'(32'(cand_r) + 1);
  assign cand_free = !fin_r[cand_r] && !blk_r[cand_r];
  assign last_step = (cnt_r == n_eff);
  assign sts.srch_end = cmd.srch_step && (cand_free || last_step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r    <= '0;
      blk_r    <= '0;
      run_r    <= '0;
      made_r   <= CW'(1);
      ltaken_r <= '0;
      qv_r     <= '0;
    end else begin
      if (cmd.exec && ex_ok) begin
        case (cmd_t'(cmd_r))
          CMD_CREATE: begin
            run_r  <= TW'(made_r);
            made_r <= made_r + CW'(1);
          end
          CMD_EXIT:   fin_r[run_r] <= 1'b1;
          CMD_LOCK:   ltaken_r[li] <= 1'b1;
          CMD_UNLOCK: ltaken_r[li] <= 1'b0;
          CMD_WAIT: begin
            qv_r[q]      <= 1'b1;
            blk_r[run_r] <= 1'b1;
            ltaken_r[li] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd.slot_done) begin
        blk_r[ram_rdata] <= 1'b0;
      end
      if (cmd.srch_step && cand_free) begin
        run_r <= cand_r;
      end
    end
  end

  // Item capture, result fields and search counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_cmd;
      li_r  <= in_lock_index;
      ci_r  <= in_cond_index;
      tt_r  <= in_target_thread;
    end
    if (cmd.exec) begin
      status_r <= ex_st;
      newt_r   <= (cmd_t'(cmd_r) == CMD_CREATE && ex_ok) ? 4'(made_r) : 4'd0;
      tdone_r  <= (cmd_t'(cmd_r) == CMD_JOIN) && tt_ok && fin_r[TW'(tt_r)];
    end
    if (cmd.srch_init) begin
      // exit marks the caller finished in this same cycle; run_r still valid
      cand_r <= wrap_next(run_r, n_eff);
      cnt_r  <= CW'(1);
    end else if (cmd.srch_step) begin
      cand_r <= nxt_cand;
      cnt_r  <= cnt_r + CW'(1);
      if (!cand_free && last_step) begin
        status_r <= ST_DEADLOCK;
      end
    end
  end

  assign out_status      = status_r;
  assign out_run_thread  = 4'(run_r);
  assign out_new_thread  = newt_r;
  assign out_target_done = tdone_r;

endmodule

[sv/tssu_checker.sv]
// Port-level checker for the thread sync unit, bound to the top level.
// Depends on tssu_pkg.
module tssu_checker import tssu_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_status,
  input logic [3:0] out_new_thread,
  input logic       out_target_done
);

  // A result stays offered until it transfers
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result dropped while stalled");

  // No new item while a result is pending
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open with result pending");

  // An accepted item leads to no result in the very next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid)
    else $error("result too early");

  // Created number only with ok status
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_thread != 4'd0 |-> out_status == ST_OK)
    else $error("new thread with error status");

  // Join done flag only with ok status and no created number
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_target_done |-> out_status == ST_OK && out_new_thread == 4'd0)
    else $error("target_done with error");

endmodule

bind thread_scheduler_sync_unit tssu_checker u_tssu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_new_thread  (out_new_thread),
  .out_target_done (out_target_done)
);

[verif/thread_scheduler_sync_unit_tb.sv]
// Testbench for thread_scheduler_sync_unit: directed and random command streams,
// checked against a scoreboard predictor of the scheduler state. Needs tssu_pkg.
module thread_scheduler_sync_unit_tb import tssu_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTHR = 16;
  localparam int NLOCK = 16;
  localparam int NCOND = 4;
  localparam int NQ = NLOCK * NCOND;

  typedef struct packed {
    status_t    status;
    logic [3:0] run_thread;
    logic [3:0] new_thread;
    logic       target_done;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_cmd = '0;
  logic [3:0] in_lock_index = '0;
  logic [1:0] in_cond_index = '0;
  logic [3:0] in_target_thread = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic [3:0] out_run_thread;
  logic [3:0] out_new_thread;
  logic out_target_done;

  // Predictor state
  logic       thr_done [NTHR];
  logic       thr_blocked [NTHR];
  logic [3:0] cur_thread;
  int         made_count;
  logic       lk_taken [NLOCK];
  logic [3:0] cq_slot [NQ][NTHR];
  int         cq_head [NQ];
  int         cq_tail [NQ];
  int         cq_fill [NQ];

  sched_result_t expected_results[$];
  int  error_count = 0;
  bit  long_hold = 1'b0;
  bit  rx_random = 1'b1;

  always #2 clk = ~clk;

  thread_scheduler_sync_unit dut (.*);

  function automatic status_t pick_next_thread();
    for (int k = 1; k <= made_count; k++) begin
      int t;
      t = (cur_thread + k) % made_count;
      if (!thr_done[t] && !thr_blocked[t]) begin
        cur_thread = t[3:0];
        return ST_OK;
      end
    end
    return ST_DEADLOCK;
  endfunction

  function automatic void clear_sched_state();
    for (int i = 0; i < NTHR; i++) begin
      thr_done[i] = 1'b0;
      thr_blocked[i] = 1'b0;
    end
    for (int i = 0; i < NLOCK; i++) lk_taken[i] = 1'b0;
    for (int i = 0; i < NQ; i++) begin
      cq_head[i] = 0;
      cq_tail[i] = 0;
      cq_fill[i] = 0;
    end
    cur_thread = '0;
    made_count = 1;
  endfunction

  function automatic sched_result_t predict_command(cmd_t cmd, int li, int ci, int tt);
    sched_result_t r;
    int q;
    r = '0;
    q = li * NCOND + ci;
    case (cmd)
      CMD_CREATE: begin
        if (made_count >= NTHR) r.status = ST_FULL;
        else begin
          r.new_thread = made_count[3:0];
          cur_thread = made_count[3:0];
          made_count++;
        end
      end
      CMD_YIELD: r.status = pick_next_thread();
      CMD_EXIT: begin
        if (cur_thread == 0) r.status = ST_HALT;
        else begin
          thr_done[cur_thread] = 1'b1;
          r.status = pick_next_thread();
        end
      end
      CMD_LOCK: begin
        if (lk_taken[li]) begin
          r.status = pick_next_thread();
          if (r.status == ST_OK) r.status = ST_BUSY;
        end else lk_taken[li] = 1'b1;
      end
      CMD_UNLOCK: lk_taken[li] = 1'b0;
      CMD_WAIT: begin
        if (!lk_taken[li]) r.status = ST_NOT_HELD;
        else if (cq_fill[q] >= NTHR) r.status = ST_FULL;
        else begin
          cq_slot[q][cq_tail[q]] = cur_thread;
          cq_tail[q] = (cq_tail[q] + 1) % NTHR;
          cq_fill[q]++;
          thr_blocked[cur_thread] = 1'b1;
          lk_taken[li] = 1'b0;
          r.status = pick_next_thread();
        end
      end
      CMD_SIGNAL: begin
        if (cq_fill[q] == 0) r.status = ST_EMPTY;
        else begin
          thr_blocked[cq_slot[q][cq_head[q]]] = 1'b0;
          cq_head[q] = (cq_head[q] + 1) % NTHR;
          cq_fill[q]--;
        end
      end
      default: begin
        if (tt >= made_count) r.status = ST_BAD_IDX;
        else if (thr_done[tt]) r.target_done = 1'b1;
        else r.status = pick_next_thread();
      end
    endcase
    r.run_thread = cur_thread;
    return r;
  endfunction

  // Send one command transfer after a random gap (if gaps); returns at the accepting edge
  task automatic send_command(cmd_t cmd, int li, int ci, int tt, bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_lock_index <= li[3:0];
    in_cond_index <= ci[1:0];
    in_target_thread <= tt[3:0];
    expected_results.push_back(predict_command(cmd, li, ci, tt));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected");
        error_count++;
      end else begin
        sched_result_t e;
        e = expected_results.pop_front();
        if (out_status != e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_status);
          error_count++;
        end
        if (out_run_thread != e.run_thread) begin
          $error("run_thread: expected %0d actual %0d", e.run_thread, out_run_thread);
          error_count++;
        end
        if (out_new_thread != e.new_thread) begin
          $error("new_thread: expected %0d actual %0d", e.new_thread, out_new_thread);
          error_count++;
        end
        if (out_target_done != e.target_done) begin
          $error("target_done: expected %0b actual %0b", e.target_done, out_target_done);
          error_count++;
        end
      end
    end
  end

  // Receiver stall: random runs of random length, or a long hold-off
  initial begin
    int n;
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
        @(posedge clk);
      end else if (rx_random) begin
        n = $urandom_range(0, 7);
        out_stall <= (n != 0);
        repeat (n == 0 ? 1 : n) @(posedge clk);
        out_stall <= 1'b0;
        n = $urandom_range(0, 7);
        repeat (n + 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic test_directed();
    // Create fills the table, then one more is rejected
    for (int i = 0; i < NTHR; i++) send_command(CMD_CREATE, 0, 0, 0);
    send_command(CMD_JOIN, 0, 0, 15);
    send_command(CMD_LOCK, 15, 3, 0);
    send_command(CMD_LOCK, 15, 3, 0);
    send_command(CMD_WAIT, 15, 3, 0);
    send_command(CMD_WAIT, 0, 0, 0);
    send_command(CMD_SIGNAL, 15, 3, 0);
    send_command(CMD_SIGNAL, 15, 3, 0);
    send_command(CMD_UNLOCK, 0, 0, 0);
    send_command(CMD_YIELD, 0, 0, 0);
    send_command(CMD_EXIT, 0, 0, 0);
    send_command(CMD_JOIN, 0, 0, 0);
    send_command(CMD_JOIN, 0, 0, 5);
    drain_results();
  endtask

  // Main only: halt on exit, bad join, self-deadlock through wait
  task automatic test_main_corner();
    send_command(CMD_EXIT, 0, 0, 0);
    send_command(CMD_JOIN, 0, 0, 3);
    send_command(CMD_LOCK, 2, 1, 0);
    send_command(CMD_WAIT, 2, 1, 0);
    send_command(CMD_SIGNAL, 2, 1, 0);
    send_command(CMD_YIELD, 0, 0, 0);
    drain_results();
  endtask

  // Weighted random commands: mostly lock/wait/signal on a few locks
  task automatic test_random(int count);
    int li, ci, sel;
    cmd_t c;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      li = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
      ci = $urandom_range(0, 3);
      if (sel < 8) c = CMD_CREATE;
      else if (sel < 20) c = CMD_YIELD;
      else if (sel < 26) c = CMD_EXIT;
      else if (sel < 46) c = CMD_LOCK;
      else if (sel < 56) c = CMD_UNLOCK;
      else if (sel < 72) c = CMD_WAIT;
      else if (sel < 90) c = CMD_SIGNAL;
      else c = CMD_JOIN;
      send_command(c, li, ci, $urandom_range(0, 15), i % 300 > 40);
    end
    drain_results();
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int i = 0; i < 12; i++) send_command(CMD_YIELD, 0, 0, 0, 1'b0);
    drain_results();
  endtask

  initial begin
    clear_sched_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_main_corner();
    test_directed();
    test_backpressure();
    // Reset-free reuse: the unit only halts, so continue with the same state
    test_random(2000);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[thread_scheduler_sync_unit.f]
sv/tssu_pkg.sv
sv/tssu_ram.sv
sv/tssu_ctrl.sv
sv/tssu_dp.sv
sv/thread_scheduler_sync_unit.sv
sv/tssu_checker.sv
verif/thread_scheduler_sync_unit_tb.sv
